// File: sv/opae_pkg.sv
// Shared types and codes of the ordered pointer array engine.
package opae_pkg;

    localparam int CMD_W = 4;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 7;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND       = 4'd0,
        CMD_PREPEND      = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_REMOVE_VALUE = 4'd3,
        CMD_REMOVE_AT    = 4'd4,
        CMD_READ         = 4'd5,
        CMD_POP_FRONT    = 4'd6,
        CMD_POP_BACK     = 4'd7,
        CMD_LENGTH       = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    // APB register map: register index is paddr / 4
    localparam int PADDR_W = 3;
    localparam logic REG_DESTROY_ENABLED = 1'b0;

endpackage

// File: sv/opae_if.sv
// Command and response channel interfaces.
interface opae_cmd_if
    import opae_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]   index;
    logic                 free_request;

    modport source (output valid, cmd, value, index, free_request, input ready);
    modport sink (input valid, cmd, value, index, free_request, output ready);
endinterface

interface opae_rsp_if
    import opae_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   result_value;
    logic [COUNT_W-1:0]   entry_count;
    logic [STATUS_W-1:0]  status;
    logic                 release_res;

    modport source (output valid, result_value, entry_count, status, release_res,
                    input ready);
    modport sink (input valid, result_value, entry_count, status, release_res,
                  output ready);
endinterface

// File: sv/opae_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module opae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: sv/ordered_pointer_array_engine_core.sv
// Top level of the ordered pointer array engine: sequencer around one entry RAM.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------------
//  cmd_ch   | in  | valid/ready     | cmd, value, index, free_request
//  rsp_ch   | out | valid/ready     | result_value, entry_count, status,
//           |     |                 | release_res
//  apb      | in  | psel/penable    | paddr, pwdata, pwrite -> prdata (pready=1)
//
// Transaction flow: length, refusals and unused codes go from idle straight to S_FIN;
//   read passes through S_RD; insert walks down from the last entry to pos (no walk
//   when pos = count), then stores; remove_at / pops walk up from pos to the last entry;
//   remove_value scans up from entry 0 and, on a match, runs straight into the shift.
// The entry RAM moves one entry per cycle (one read, one write) during a walk. One
// transaction is in flight; a finished response waits in the output register, and a
// new command is taken as soon as the sequencer is idle.
// rst_n clears control state only; the RAM holds no reset value and only
// entries below the count are ever read.
module ordered_pointer_array_engine_core
    import opae_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    opae_cmd_if.sink           cmd_ch,
    opae_rsp_if.source         rsp_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,   // search for a value
        S_DN   = 6'b000100,   // remove: shift later entries down
        S_UP   = 6'b001000,   // insert: shift entries up, then store
        S_RD   = 6'b010000,   // single read
        S_FIN  = 6'b100000    // hand result to the output register
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  destroy_reg;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic                  done_reg, done_next;     // all reads of the walk issued
    logic                  rvalid_reg;              // RAM data valid this cycle
    logic [AW-1:0]         raddr_reg;               // address of that data
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    status_t               status_reg, status_next;
    logic                  rel_reg, rel_next;

    // Output register
    logic                  ovalid_reg;
    logic [VALUE_W-1:0]    oval_reg;
    logic [COUNT_W-1:0]    ocnt_reg;
    status_t               ostat_reg;
    logic                  orel_reg;

    // RAM ports
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rdata;

    logic                     accept;
    logic                     load_out;
    logic [IW-1:0]            cnt_ext;
    logic [IW-1:0]            idx_ext;
    logic [IW-1:0]            ins_pos;
    logic [AW-1:0]            last_addr;
    logic                     full;
    logic [DATA_WIDTH+31:0]   in_word_ext;
    logic [DATA_WIDTH+31:0]   res_ext;

    opae_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_DESTROY_ENABLED)
        begin
            prdata = {31'd0, destroy_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            destroy_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DESTROY_ENABLED))
        begin
            destroy_reg <= pwdata[0];
        end
    end

    // ---------------- command decode helpers ----------------
    assign accept      = cmd_ch.valid && cmd_ch.ready;
    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign cnt_ext     = IW'(count_reg);
    assign idx_ext     = IW'(cmd_ch.index);
    assign full        = (count_reg == CW'(CAPACITY));
    assign last_addr   = AW'(count_reg - 1'b1);
    // Inserted and searched words are cut to DATA_WIDTH bits
    assign in_word_ext = {{DATA_WIDTH{1'b0}}, cmd_ch.value};

    always_comb
    begin
        priority if (cmd_ch.cmd == CMD_APPEND)
        begin
            ins_pos = cnt_ext;
        end
        else if (cmd_ch.cmd == CMD_PREPEND)
        begin
            ins_pos = '0;
        end
        else
        begin
            ins_pos = idx_ext;
        end
    end

    // Output register can take a new result when empty or being drained
    assign load_out = (state_reg == S_FIN) && (!ovalid_reg || rsp_ch.ready);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        word_next   = word_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        done_next   = done_reg;
        res_next    = res_reg;
        status_next = status_reg;
        rel_next    = rel_reg;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next   = in_word_ext[DATA_WIDTH-1:0];
                    res_next    = '0;
                    status_next = ST_OK;
                    rel_next    = 1'b0;
                    state_next  = S_FIN;
                    unique case (cmd_ch.cmd)
                        CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT:
                        begin
                            // range test wins over the full test
                            priority if (ins_pos > cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = AW'(ins_pos);
                                ptr_next   = last_addr;
                                done_next  = (ins_pos == cnt_ext);
                                state_next = S_UP;
                            end
                        end
                        CMD_REMOVE_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                done_next  = 1'b0;
                                rel_next   = cmd_ch.free_request && destroy_reg;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_REMOVE_AT:
                        begin
                            priority if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (idx_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                pos_next   = AW'(cmd_ch.index);
                                ptr_next   = AW'(cmd_ch.index);
                                done_next  = 1'b0;
                                rel_next   = cmd_ch.free_request && destroy_reg;
                                state_next = S_DN;
                            end
                        end
                        CMD_READ:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(cmd_ch.index);
                                state_next = S_RD;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pos_next   = (cmd_ch.cmd == CMD_POP_FRONT) ? '0 : last_addr;
                                ptr_next   = (cmd_ch.cmd == CMD_POP_FRONT) ? '0 : last_addr;
                                done_next  = 1'b0;
                                state_next = S_DN;
                            end
                        end
                        default:
                        begin
                            // length and unused codes: answer with the count only
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN, S_DN:
            begin
                // ascending read walk up to the last entry
                if (!done_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg;
                    if (ptr_reg == last_addr)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = AW'(ptr_reg + 1'b1);
                    end
                end

                if (state_reg == S_SCAN)
                begin
                    if (rvalid_reg && (rdata == word_reg))
                    begin
                        // first match: reads already in flight feed the shift
                        res_next   = rdata;
                        pos_next   = raddr_reg;
                        state_next = S_DN;
                    end
                    else if (done_reg && !rvalid_reg)
                    begin
                        status_next = ST_ABSENT;
                        rel_next    = 1'b0;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    if (rvalid_reg)
                    begin
                        if (raddr_reg == pos_reg)
                        begin
                            res_next = rdata;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(raddr_reg - 1'b1);
                            wr_data = rdata;
                        end
                    end
                    if (done_reg && !rvalid_reg)
                    begin
                        count_next = CW'(count_reg - 1'b1);
                        state_next = S_FIN;
                    end
                end
            end

            S_UP:
            begin
                // descending read walk from the last entry down to pos
                if (!done_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg;
                    if (ptr_reg == pos_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = AW'(ptr_reg - 1'b1);
                    end
                end
                if (rvalid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(raddr_reg + 1'b1);
                    wr_data = rdata;
                end
                else if (done_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = word_reg;
                    count_next = CW'(count_reg + 1'b1);
                    state_next = S_FIN;
                end
            end

            S_RD:
            begin
                res_next   = rdata;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b1;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            rvalid_reg <= rd_en;
        end
    end

    // Working payload, no reset needed
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        raddr_reg  <= rd_addr;
        res_reg    <= res_next;
        status_reg <= status_next;
        rel_reg    <= rel_next;
    end

    // ---------------- response output register ----------------
    assign res_ext = {32'd0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            oval_reg  <= res_ext[VALUE_W-1:0];
            ocnt_reg  <= COUNT_W'(count_reg);
            ostat_reg <= status_reg;
            orel_reg  <= rel_reg;
        end
    end

    assign rsp_ch.valid        = ovalid_reg;
    assign rsp_ch.result_value = oval_reg;
    assign rsp_ch.entry_count  = ocnt_reg;
    assign rsp_ch.status       = ostat_reg;
    assign rsp_ch.release_res  = orel_reg;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the ordered pointer array engine core.
module testbench
    import opae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Engine sizing used for this run; the predictor mirrors the same depth.
    localparam int ARRAY_DEPTH = 64;

    // Register map: index 0 is the only register; index 1 is unmapped and
    // writes to it must be ignored.
    localparam int REG_UNMAPPED = 1;

    // A transaction can walk the whole array and then sit in the output
    // register while the receiver stalls, so the watchdog is set well above
    // the longest quiet stretch a correct block can show.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 80;
    localparam int RANDOM_ITEMS   = 400;

    // One expected response, field for field as on rsp_ch.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                release_flag;
    } array_rsp_t;

    logic clk;
    logic rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    opae_cmd_if cmd_ch();
    opae_rsp_if rsp_ch();

    ordered_pointer_array_engine_core #(
        .CAPACITY   (ARRAY_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .rsp_ch  (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the array, its count and the destroy enable.
    // Updated once per accepted command transaction, in acceptance order.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] shadow_entries [ARRAY_DEPTH];
    int                 shadow_count;
    logic               shadow_destroy_en;

    array_rsp_t pending_rsp [$];   // responses owed by the block, oldest first
    int         mismatches = 0;
    int         sender_idle_pct;   // chance per cycle that the sender idles
    int         receiver_stall_pct;
    int         quiet_cycles = 0;
    bit         filling;           // random mix leans toward growing the array

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Removes the entry at pos and closes the gap.
    function automatic logic [VALUE_W-1:0] shadow_take(int pos);
        logic [VALUE_W-1:0] word;
        word = shadow_entries[pos];
        for (int i = pos + 1; i < shadow_count; i++)
            shadow_entries[i - 1] = shadow_entries[i];
        shadow_count--;
        return word;
    endfunction

    // Applies one command to the shadow array and returns the response.
    function automatic array_rsp_t apply_command(logic [CMD_W-1:0] op,
                                                 logic [VALUE_W-1:0] word,
                                                 logic [INDEX_W-1:0] pos,
                                                 logic free_req);
        array_rsp_t rsp;
        int         at;
        bit         hit;
        rsp = '0;
        rsp.status = ST_OK;
        case (op)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT:
            begin
                at = (op == CMD_APPEND) ? shadow_count :
                     (op == CMD_PREPEND) ? 0 : int'(pos);
                // an index past the end wins over a full array
                if (at > shadow_count)
                    rsp.status = ST_RANGE;
                else if (shadow_count >= ARRAY_DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > at; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[at] = word;
                    shadow_count++;
                end
            end
            CMD_REMOVE_VALUE:
            begin
                if (shadow_count == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    hit = 1'b0;
                    at = 0;
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        if (!hit && shadow_entries[i] == word)
                        begin
                            hit = 1'b1;
                            at = i;
                        end
                    end
                    if (hit)
                    begin
                        rsp.value = shadow_take(at);
                        rsp.release_flag = free_req & shadow_destroy_en;
                    end
                    else
                        rsp.status = ST_ABSENT;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (shadow_count == 0)
                    rsp.status = ST_EMPTY;
                else if (int'(pos) >= shadow_count)
                    rsp.status = ST_RANGE;
                else
                begin
                    rsp.value = shadow_take(int'(pos));
                    rsp.release_flag = free_req & shadow_destroy_en;
                end
            end
            CMD_READ:
            begin
                if (int'(pos) >= shadow_count)
                    rsp.status = ST_RANGE;
                else
                    rsp.value = shadow_entries[pos];
            end
            CMD_POP_FRONT:
            begin
                if (shadow_count == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.value = shadow_take(0);
            end
            CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.value = shadow_take(shadow_count - 1);
            end
            default:
            begin
                // length and unused codes leave the array alone
            end
        endcase
        rsp.count = COUNT_W'(shadow_count);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Command side: one transaction per call. valid is only lowered when
    // the sender idles or drains, so back-to-back transactions keep it high.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                             input logic [INDEX_W-1:0] pos, input logic free_req);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= op;
        cmd_ch.value        <= word;
        cmd_ch.index        <= pos;
        cmd_ch.free_request <= free_req;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_rsp.push_back(apply_command(op, word, pos, free_req));
    endtask

    // Holds the sender off until every owed response is back.
    task automatic drain(input int settle);
        cmd_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input int reg_index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_index * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_index == int'(REG_DESTROY_ENABLED))
            shadow_destroy_en = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Config changes only with the engine idle.
    task automatic set_destroy(input int reg_index, input logic [31:0] data);
        drain(4);
        reg_write(reg_index, data);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall on ready, check on every accepted
    // response transaction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_ch.ready <= (receiver_stall_pct == 0) ||
                        ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic note_mismatch(input array_rsp_t want, input array_rsp_t got, input bit orphan);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (orphan)
                $display("[%0t] response with none owed: value=%h count=%0d status=%0d rel=%b",
                         $realtime, got.value, got.count, got.status, got.release_flag);
            else
                $display("[%0t] response mismatch: exp value=%h count=%0d status=%0d rel=%b",
                         $realtime, want.value, want.count, want.status, want.release_flag,
                         " got value=%h count=%0d status=%0d rel=%b",
                         got.value, got.count, got.status, got.release_flag);
        end
    endtask

    always @(posedge clk)
    begin : check_responses
        array_rsp_t want;
        array_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.value        = rsp_ch.result_value;
            got.count        = rsp_ch.entry_count;
            got.status       = rsp_ch.status;
            got.release_flag = rsp_ch.release_res;
            if (pending_rsp.size() == 0)
                note_mismatch(got, got, 1'b1);
            else
            begin
                want = pending_rsp.pop_front();
                if (got.value !== want.value || got.count !== want.count ||
                    got.status !== want.status || got.release_flag !== want.release_flag)
                    note_mismatch(want, got, 1'b0);
            end
        end
    end

    // Watchdog: any cycle with a handshake or a register access resets it.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ordered_pointer_array_engine_core regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly full-range words; some from a tiny pool so duplicates appear
    // and remove_value has to pick the first match.
    function automatic logic [VALUE_W-1:0] pick_word();
        if ($urandom_range(3) == 0)
            return VALUE_W'($urandom_range(5));
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] choose_command(input bit grow);
        int roll;
        roll = $urandom_range(99);
        if (roll >= 95)
            return CMD_W'($urandom_range(15));
        if (grow)
        begin
            if (roll < 20) return CMD_APPEND;
            if (roll < 35) return CMD_PREPEND;
            if (roll < 55) return CMD_INSERT_AT;
            if (roll < 63) return CMD_REMOVE_VALUE;
            if (roll < 70) return CMD_REMOVE_AT;
            if (roll < 80) return CMD_READ;
            if (roll < 85) return CMD_POP_FRONT;
            if (roll < 90) return CMD_POP_BACK;
            return CMD_LENGTH;
        end
        if (roll < 8)  return CMD_APPEND;
        if (roll < 13) return CMD_PREPEND;
        if (roll < 20) return CMD_INSERT_AT;
        if (roll < 40) return CMD_REMOVE_VALUE;
        if (roll < 55) return CMD_REMOVE_AT;
        if (roll < 70) return CMD_READ;
        if (roll < 80) return CMD_POP_FRONT;
        if (roll < 90) return CMD_POP_BACK;
        return CMD_LENGTH;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every non-inserting command against an empty array.
    task automatic test_empty_array();
        send_item(CMD_READ,         '0, '0, 1'b0);
        send_item(CMD_REMOVE_VALUE, '0, '0, 1'b1);
        send_item(CMD_REMOVE_AT,    '0, '0, 1'b1);
        send_item(CMD_POP_FRONT,    '0, '0, 1'b0);
        send_item(CMD_POP_BACK,     '0, '0, 1'b0);
        send_item(CMD_LENGTH,       '0, '0, 1'b0);
    endtask

    // Inserts at both ends and in the middle, range refusals, reads, a
    // missing value, unused codes, then removals with and without release.
    task automatic test_basic_ops();
        send_item(CMD_APPEND,       32'hFFFF_FFFF, '0, 1'b0);
        send_item(CMD_APPEND,       32'h0000_0000, '0, 1'b0);
        send_item(CMD_PREPEND,      32'h8000_0000, '0, 1'b0);
        send_item(CMD_INSERT_AT,    32'h0000_0001, 7'd1, 1'b0);
        send_item(CMD_INSERT_AT,    32'h1234_5678, 7'd4, 1'b0);   // at the end
        send_item(CMD_INSERT_AT,    32'h5555_5555, 7'd6, 1'b0);   // past the end
        send_item(CMD_INSERT_AT,    32'hAAAA_AAAA, 7'h7F, 1'b0);
        send_item(CMD_READ,         '0, 7'd0, 1'b0);
        send_item(CMD_READ,         '0, 7'd4, 1'b0);
        send_item(CMD_READ,         '0, 7'd5, 1'b0);
        send_item(CMD_REMOVE_VALUE, 32'hDEAD_BEEF, '0, 1'b1);
        send_item(CMD_W'(9),        32'hFFFF_FFFF, 7'h7F, 1'b1);
        send_item(CMD_W'(15),       32'hFFFF_FFFF, 7'h7F, 1'b1);
        send_item(CMD_LENGTH,       '0, '0, 1'b0);

        set_destroy(int'(REG_DESTROY_ENABLED), 32'h1);
        send_item(CMD_REMOVE_VALUE, 32'h0000_0000, '0, 1'b1);     // release raised
        send_item(CMD_REMOVE_AT,    '0, 7'd0, 1'b1);              // release raised
        send_item(CMD_REMOVE_AT,    '0, 7'd0, 1'b0);              // no free asked
        send_item(CMD_POP_FRONT,    '0, '0, 1'b1);                // pops never release
        send_item(CMD_POP_BACK,     '0, '0, 1'b1);

        // unmapped register must not touch the enable; then clear it with
        // a word whose low bit is zero
        set_destroy(REG_UNMAPPED, 32'h0);
        set_destroy(int'(REG_DESTROY_ENABLED), 32'hFFFF_FFFE);
        send_item(CMD_APPEND,       32'h0000_0002, '0, 1'b0);
        send_item(CMD_REMOVE_AT,    '0, 7'd0, 1'b1);              // enable off: no release
    endtask

    // Fill to capacity, then every insert flavor against a full array.
    task automatic test_full_array();
        while (shadow_count < ARRAY_DEPTH)
            send_item(CMD_APPEND, pick_word(), '0, 1'b0);
        send_item(CMD_APPEND,    32'hFFFF_FFFF, '0, 1'b0);
        send_item(CMD_PREPEND,   32'hFFFF_FFFF, '0, 1'b0);
        send_item(CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd0, 1'b0);
        send_item(CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd64, 1'b0);     // full
        send_item(CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd65, 1'b0);     // range before full
        send_item(CMD_READ,      '0, 7'd63, 1'b0);
        send_item(CMD_READ,      '0, 7'd64, 1'b0);
        send_item(CMD_REMOVE_AT, '0, 7'd64, 1'b1);
        send_item(CMD_REMOVE_AT, '0, 7'd0, 1'b1);                 // longest shift
        send_item(CMD_INSERT_AT, pick_word(), 7'd0, 1'b0);        // longest shift up
    endtask

    // Random traffic: four idle/stall phases, the destroy enable changed
    // between them, the array driven repeatedly between empty and full.
    task automatic test_random_traffic();
        int                 idle_set  [4] = '{0, 74, 0, 32};
        int                 stall_set [4] = '{0, 0, 74, 32};
        logic [31:0]        cfg_set   [4] = '{32'h1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0};
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] word;
        logic [INDEX_W-1:0] pos;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_destroy(int'(REG_DESTROY_ENABLED), cfg_set[phase]);
            sender_idle_pct    = idle_set[phase];
            receiver_stall_pct = stall_set[phase];
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                // turn around at the ends, lingering a little so refusals show up
                if (shadow_count == ARRAY_DEPTH && $urandom_range(7) == 0)
                    filling = 1'b0;
                else if (shadow_count == 0 && $urandom_range(3) == 0)
                    filling = 1'b1;
                else if ($urandom_range(99) == 0)
                    filling = ~filling;

                op = choose_command(filling);
                word = pick_word();
                if (op == CMD_REMOVE_VALUE && shadow_count > 0 && $urandom_range(4) != 0)
                    word = shadow_entries[$urandom_range(shadow_count - 1)];
                if ($urandom_range(99) < 85)
                    pos = INDEX_W'($urandom_range(shadow_count));
                else
                    pos = INDEX_W'($urandom_range(127));

                // sender holds off until the pipeline is empty now and then
                if (n == RANDOM_ITEMS / 2 || $urandom_range(127) == 0)
                    drain(2);
                send_item(op, word, pos, 1'(($urandom_range(1))));
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = '0;
        cmd_ch.value        = '0;
        cmd_ch.index        = '0;
        cmd_ch.free_request = 1'b0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        filling             = 1'b1;
        shadow_count        = 0;
        shadow_destroy_en   = 1'b0;
        foreach (shadow_entries[i])
            shadow_entries[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_array();
        test_basic_ops();
        test_full_array();
        test_random_traffic();

        drain(TAIL_CYCLES);
        if (mismatches == 0)
            $display("ordered_pointer_array_engine_core regression: pass");
        else
            $display("ordered_pointer_array_engine_core regression: fail");
        $finish;
    end

endmodule

// File: ordered_pointer_array_engine_core.f
sv/opae_pkg.sv
sv/opae_if.sv
sv/opae_ram.sv
sv/ordered_pointer_array_engine_core.sv
verif/testbench.sv
